FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file kq_checker.sv.
// No dependencies; each macro expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every edge outside reset.
`define KQ_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("keypad qualifier check failed");

// Antecedent at one edge implies consequent from the next edge on.
`define KQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
    else $error("keypad qualifier check failed");

`endif

FILE: rtl/kq_pkg.sv
// Shared constants, key codes, register indexes and types for the keypad qualifier.
// No dependencies.
package kq_pkg;

  localparam int HOLD_TIME_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TICK_W     = 8;
  localparam int MS_W       = 16;
  localparam int DEB_W      = 3;
  localparam int KEY_W      = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_TICK_LENGTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PRESS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE       = 3'd3;

  localparam logic [TICK_W-1:0] TICK_LENGTH_RST = 8'd10;
  localparam logic [MS_W-1:0]   LONG_PRESS_RST  = 16'd700;
  localparam logic [MS_W-1:0]   SHORT_PRESS_RST = 16'd30;
  localparam logic [DEB_W-1:0]  DEBOUNCE_RST    = 3'd3;

  localparam logic [KEY_W-1:0] KEY_NONE = 3'd0;
  localparam logic [KEY_W-1:0] KEY_HOME = 3'd1;
  localparam logic [KEY_W-1:0] KEY_NEXT = 3'd2;
  localparam logic [KEY_W-1:0] KEY_UP   = 3'd3;
  localparam logic [KEY_W-1:0] KEY_DOWN = 3'd4;

  typedef struct packed {
    logic [TICK_W-1:0] tick_length_ms;
    logic [MS_W-1:0]   long_press_ms;
    logic [MS_W-1:0]   short_press_min_ms;
    logic [DEB_W-1:0]  debounce_samples;
  } cfg_t;

  typedef struct packed {
    logic home;
    logic next;
  } a_event_t;

endpackage

FILE: rtl/kq_cfg_regs.sv
// Configuration register file of the keypad qualifier.
// Depends on kq_pkg.
module kq_cfg_regs import kq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_length_ms     <= TICK_LENGTH_RST;
      cfg.long_press_ms      <= LONG_PRESS_RST;
      cfg.short_press_min_ms <= SHORT_PRESS_RST;
      cfg.debounce_samples   <= DEBOUNCE_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_TICK_LENGTH: cfg.tick_length_ms     <= wr_data[TICK_W-1:0];
        CFG_LONG_PRESS:  cfg.long_press_ms      <= wr_data[MS_W-1:0];
        CFG_SHORT_PRESS: cfg.short_press_min_ms <= wr_data[MS_W-1:0];
        CFG_DEBOUNCE:    cfg.debounce_samples   <= wr_data[DEB_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/kq_hold.sv
// Hold timer of button A: saturating hold time, long press and short release events.
// Depends on kq_pkg.
module kq_hold import kq_pkg::*; #(
  parameter int HOLD_TIME_BITS = HOLD_TIME_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     level,
  input  cfg_t     cfg,
  output a_event_t evt
);

  localparam int CMP_W = (HOLD_TIME_BITS > MS_W) ? HOLD_TIME_BITS : MS_W;

  logic [HOLD_TIME_BITS-1:0] hold_time;
  logic [HOLD_TIME_BITS-1:0] hold_time_next;
  logic [HOLD_TIME_BITS:0]   sum;
  logic                      long_fired;
  logic                      pressed;

  assign pressed = !level;
  assign sum = {1'b0, hold_time} + (HOLD_TIME_BITS+1)'(cfg.tick_length_ms);
  assign hold_time_next = sum[HOLD_TIME_BITS] ? '1 : sum[HOLD_TIME_BITS-1:0];

  assign evt.home = pressed && !long_fired &&
                    (CMP_W'(hold_time_next) >= CMP_W'(cfg.long_press_ms));
  assign evt.next = !pressed && !long_fired &&
                    (CMP_W'(hold_time) >= CMP_W'(cfg.short_press_min_ms));

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_time  <= '0;
      long_fired <= 1'b0;
    end else if (en) begin
      if (pressed) begin
        hold_time <= hold_time_next;
        if (evt.home) begin
          long_fired <= 1'b1;
        end
      end else begin
        hold_time  <= '0;
        long_fired <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/kq_debounce.sv
// Sample-count debouncer for one active-low button, one shot per press.
// Depends on kq_pkg.
module kq_debounce import kq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             level,
  input  logic [DEB_W-1:0] samples,
  output logic             fire
);

  logic [DEB_W-1:0] sample_count;
  logic [DEB_W-1:0] sample_count_next;
  logic             armed;
  logic             pressed;

  assign pressed           = !level;
  assign sample_count_next = (sample_count < samples) ? sample_count + 3'd1 : sample_count;
  assign fire              = pressed && armed && (sample_count_next >= samples);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      armed        <= 1'b1;
    end else if (en) begin
      if (pressed) begin
        sample_count <= sample_count_next;
        if (fire) begin
          armed <= 1'b0;
        end
      end else begin
        sample_count <= '0;
        armed        <= 1'b1;
      end
    end
  end

endmodule

FILE: rtl/three_button_keypad_qualifier_top.sv
// Keypad qualifier top level: input register, button A timer, B and C debouncers,
// priority select and result register. Depends on kq_pkg and the kq_* modules.
//
// One poll tick is one input beat and gives exactly one key_code beat. A tick
// can be accepted every clock while in_stall is low; it is held in the input
// register and moves into the result register once that register is empty or
// being taken. A stalled result holds while one more tick waits in the input
// register. Button state advances as a tick moves into the result register.
// The configuration port is always ready; registers are meant to be written
// while no tick is in flight.
module three_button_keypad_qualifier_top import kq_pkg::*; #(
  parameter int HOLD_TIME_BITS = HOLD_TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  level_a,
  input  logic                  level_b,
  input  logic                  level_c,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [KEY_W-1:0]      key_code,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg;
  a_event_t   a_evt;
  logic       s1_valid;
  logic       s1_a;
  logic       s1_b;
  logic       s1_c;
  logic       advance;
  logic       take;
  logic       b_en;
  logic       c_en;
  logic       b_fire;
  logic       c_fire;
  logic [KEY_W-1:0] key_code_next;

  assign cfg_ready = 1'b1;

  kq_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign advance  = !out_valid || !out_stall;
  assign take     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_a <= level_a;
      s1_b <= level_b;
      s1_c <= level_c;
    end
  end

  kq_hold #(
    .HOLD_TIME_BITS (HOLD_TIME_BITS)
  ) u_hold (
    .clk   (clk),
    .rst   (rst),
    .en    (take),
    .level (s1_a),
    .cfg   (cfg),
    .evt   (a_evt)
  );

  // later buttons are not sampled once an earlier one has an event
  assign b_en = take && !a_evt.home && !a_evt.next;
  assign c_en = b_en && !b_fire;

  kq_debounce u_deb_b (
    .clk     (clk),
    .rst     (rst),
    .en      (b_en),
    .level   (s1_b),
    .samples (cfg.debounce_samples),
    .fire    (b_fire)
  );

  kq_debounce u_deb_c (
    .clk     (clk),
    .rst     (rst),
    .en      (c_en),
    .level   (s1_c),
    .samples (cfg.debounce_samples),
    .fire    (c_fire)
  );

  always_comb begin
    if (a_evt.home) begin
      key_code_next = KEY_HOME;
    end else if (a_evt.next) begin
      key_code_next = KEY_NEXT;
    end else if (b_fire) begin
      key_code_next = KEY_UP;
    end else if (c_fire) begin
      key_code_next = KEY_DOWN;
    end else begin
      key_code_next = KEY_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      key_code <= key_code_next;
    end
  end

endmodule

FILE: rtl/kq_checker.sv
// Port-level checks for the keypad qualifier, bound to its top level.
// Depends on kq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kq_checker import kq_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [KEY_W-1:0]      key_code
);

  // only known key codes leave the block
  `KQ_ASSERT_ALWAYS(a_code_range, !out_valid || (key_code <= KEY_DOWN))

  // input backs up only behind a stalled result
  `KQ_ASSERT_ALWAYS(a_stall_cause, !in_stall || (out_valid && out_stall))

  // every accepted tick is followed by out_valid being set
  `KQ_ASSERT_NEXT(a_result_due, in_valid && !in_stall, ##1 out_valid)

  `KQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(key_code))

endmodule

bind three_button_keypad_qualifier_top kq_checker u_kq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .key_code  (key_code)
);

FILE: tb/three_button_keypad_qualifier_top_tb.sv
// Self-checking testbench for the three-button keypad qualifier top level.
// Depends on kq_pkg and the RTL; a built-in predictor computes each key code and
// a monitor compares every output beat against it under random idle and stall.
`timescale 1ns / 100ps

module three_button_keypad_qualifier_top_tb;
  import kq_pkg::*;

  localparam int HT_BITS      = HOLD_TIME_BITS_DEF;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_OFF_LEN = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES       = 8;
  localparam int PHASE_TICKS  = 80;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST = CFG_DEBOUNCE;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  level_a = 1'b1;
  logic                  level_b = 1'b1;
  logic                  level_c = 1'b1;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [KEY_W-1:0]      key_code;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor copy of the settings and button state
  logic [TICK_W-1:0]  tick_ms  = TICK_LENGTH_RST;
  logic [MS_W-1:0]    long_ms  = LONG_PRESS_RST;
  logic [MS_W-1:0]    short_ms = SHORT_PRESS_RST;
  logic [DEB_W-1:0]   deb_n    = DEBOUNCE_RST;
  logic [HT_BITS-1:0] hold_ms  = '0;
  bit                 a_long_done = 1'b0;
  bit [DEB_W-1:0]     b_cnt = '0;
  bit                 b_arm = 1'b1;
  bit [DEB_W-1:0]     c_cnt = '0;
  bit                 c_arm = 1'b1;

  logic [KEY_W-1:0] expected_keys[$];
  logic [KEY_W-1:0] key_want;
  int  err_count     = 0;
  int  ticks_sent    = 0;
  int  quiet_cycles  = 0;
  int  hold_off_left = 0;
  int  stall_left    = 0;
  bit  tx_idle_en    = 1'b1;
  bit  rx_idle_en    = 1'b1;
  bit  in_on         = 1'b0;
  bit  cfg_on        = 1'b0;

  three_button_keypad_qualifier_top #(
    .HOLD_TIME_BITS(HT_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .level_a  (level_a),
    .level_b  (level_b),
    .level_c  (level_c),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .key_code (key_code),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_error(input string msg);
    $display("ERROR: %s", msg);
    err_count++;
  endtask

  task automatic debounce_step(input bit lvl, inout bit [DEB_W-1:0] cnt, inout bit arm,
                               output bit hit);
    hit = 1'b0;
    if (!lvl) begin
      if (cnt < deb_n) cnt = cnt + 1'b1;
      if (cnt >= deb_n && arm) begin
        arm = 1'b0;
        hit = 1'b1;
      end
    end else begin
      cnt = '0;
      arm = 1'b1;
    end
  endtask

  task automatic predict_key(input bit a, input bit b, input bit c,
                             output logic [KEY_W-1:0] code);
    logic [HT_BITS:0] sum;
    bit a_event;
    bit hit;
    code = KEY_NONE;
    a_event = 1'b0;
    if (!a) begin
      sum = {1'b0, hold_ms} + (HT_BITS+1)'(tick_ms);
      hold_ms = sum[HT_BITS] ? {HT_BITS{1'b1}} : sum[HT_BITS-1:0];
      if (hold_ms >= long_ms && !a_long_done) begin
        a_long_done = 1'b1;
        code = KEY_HOME;
        a_event = 1'b1;
      end
    end else begin
      a_event = (hold_ms >= short_ms) && !a_long_done;
      hold_ms = '0;
      a_long_done = 1'b0;
      if (a_event) code = KEY_NEXT;
    end
    if (!a_event) begin
      debounce_step(b, b_cnt, b_arm, hit);
      if (hit) begin
        code = KEY_UP;
      end else begin
        debounce_step(c, c_cnt, c_arm, hit);
        if (hit) code = KEY_DOWN;
      end
    end
  endtask

  task automatic cfg_release();
    if (cfg_on) begin
      cfg_valid <= 1'b0;
      cfg_on = 1'b0;
    end
  endtask

  task automatic send_tick(input bit a, input bit b, input bit c);
    logic [KEY_W-1:0] k;
    cfg_release();
    if (tx_idle_en && $urandom_range(0, 9) == 0) begin
      if (in_on) begin
        in_valid <= 1'b0;
        in_on = 1'b0;
      end
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    if (!in_on) begin
      in_valid <= 1'b1;
      in_on = 1'b1;
    end
    level_a <= a;
    level_b <= b;
    level_c <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_key(a, b, c, k);
    expected_keys.push_back(k);
    ticks_sent++;
  endtask

  task automatic wait_drained();
    if (expected_keys.size() != 0) begin
      if (in_on) begin
        in_valid <= 1'b0;
        in_on = 1'b0;
      end
      while (expected_keys.size() != 0) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_drained();
    if (!cfg_on) begin
      cfg_valid <= 1'b1;
      cfg_on = 1'b1;
    end
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_TICK_LENGTH: tick_ms  = data[TICK_W-1:0];
      CFG_LONG_PRESS:  long_ms  = data[MS_W-1:0];
      CFG_SHORT_PRESS: short_ms = data[MS_W-1:0];
      CFG_DEBOUNCE:    deb_n    = data[DEB_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input int tick, input int lng, input int shrt, input int deb);
    write_reg(CFG_TICK_LENGTH, CFG_DATA_W'(tick));
    write_reg(CFG_LONG_PRESS, CFG_DATA_W'(lng));
    write_reg(CFG_SHORT_PRESS, CFG_DATA_W'(shrt));
    write_reg(CFG_DEBOUNCE, CFG_DATA_W'(deb));
  endtask

  function automatic bit rand_level();
    return $urandom_range(0, 3) != 0;
  endfunction

  function automatic bit rand_bit();
    return $urandom_range(0, 1) != 0;
  endfunction

  task automatic send_gesture();
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    n = $urandom_range(1, 16);
    case (kind)
      0, 1, 2: begin
        repeat (n) send_tick(1'b0, rand_level(), rand_level());
        send_tick(1'b1, rand_level(), rand_level());
      end
      3, 4, 5: begin
        repeat ($urandom_range(0, 3)) send_tick(1'b1, rand_bit(), 1'b1);
        repeat (n) send_tick(1'b1, 1'b0, rand_level());
        send_tick(1'b1, 1'b1, 1'b1);
      end
      6, 7: begin
        repeat ($urandom_range(0, 3)) send_tick(1'b1, 1'b1, rand_bit());
        repeat (n) send_tick(1'b1, rand_level(), 1'b0);
        send_tick(1'b1, 1'b1, 1'b1);
      end
      8: begin
        repeat (n) send_tick(!rand_level(), !rand_level(), !rand_level());
        send_tick(1'b1, 1'b1, 1'b1);
      end
      default: begin
        repeat (n) send_tick(rand_bit(), rand_bit(), rand_bit());
      end
    endcase
  endtask

  task automatic random_config();
    int tick;
    int lng;
    int shrt;
    case ($urandom_range(0, 5))
      0: tick = 0;
      1: tick = 255;
      2: tick = 1;
      default: tick = $urandom_range(1, 255);
    endcase
    case ($urandom_range(0, 5))
      0: lng = 0;
      1: lng = 65535;
      2: lng = 1;
      default: lng = tick * $urandom_range(1, 12);
    endcase
    case ($urandom_range(0, 4))
      0: shrt = 0;
      1: shrt = 65535;
      default: shrt = tick * $urandom_range(0, 6);
    endcase
    if (lng > 65535) lng = 65535;
    if (shrt > 65535) shrt = 65535;
    // upper data bits beyond the tick and debounce field widths must be dropped
    write_all(($urandom_range(0, 255) << TICK_W) | tick, lng, shrt,
              ($urandom_range(0, 8191) << DEB_W) | $urandom_range(0, 7));
    if ($urandom_range(0, 2) == 0)
      write_reg(CFG_IDX_W'($urandom_range(CFG_LAST + 1, (1 << CFG_IDX_W) - 1)),
                CFG_DATA_W'($urandom_range(0, 65535)));
  endtask

  task automatic test_defaults();
    send_tick(1'b1, 1'b1, 1'b1);
    repeat (3) send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
    repeat (2) send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
    repeat (4) send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
    repeat (3) send_tick(1'b1, 1'b1, 1'b0);
    repeat (2) send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_events();
    write_all(100, 300, 150, 1);
    repeat (4) send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_hold_saturation();
    write_all(254, 65535, 65535, 2);
    repeat (262) send_tick(1'b0, rand_bit(), rand_bit());
    send_tick(1'b1, 1'b1, 1'b1);
    write_reg(CFG_TICK_LENGTH, 255);
    repeat (8) send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_zero_settings();
    write_all(0, 0, 0, 0);
    repeat (2) send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
    write_reg(CFG_LONG_PRESS, 1);
    repeat (3) send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_threshold_lowered();
    write_all(1, 65535, 65535, 7);
    repeat (5) send_tick(1'b1, 1'b0, 1'b1);
    write_reg(CFG_DEBOUNCE, 3);
    repeat (2) send_tick(1'b1, 1'b0, 1'b1);
    write_reg(CFG_DEBOUNCE, 7);
    repeat (6) send_tick(1'b1, 1'b1, 1'b0);
    write_reg(CFG_DEBOUNCE, 2);
    repeat (2) send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_ignored_index();
    int i;
    write_all(50, 200, 100, 2);
    for (i = CFG_LAST + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom_range(0, 65535)));
    repeat (4) send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_backpressure();
    random_config();
    tx_idle_en = 1'b0;
    hold_off_left = HOLD_OFF_LEN;
    repeat (4) send_gesture();
    wait_drained();
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_phases();
    int p;
    int target;
    for (p = 0; p < PHASES; p++) begin
      random_config();
      if (p == PHASES - 1) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      target = ticks_sent + PHASE_TICKS;
      while (ticks_sent < target) send_gesture();
    end
  endtask

  // result side: random stall bursts plus the long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_off_left > 0) begin
      out_stall <= 1'b1;
      hold_off_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 14);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_keys.size() == 0) begin
        report_error($sformatf("key beat %0d with no tick pending at %0t", key_code, $time));
      end else begin
        key_want = expected_keys.pop_front();
        if (key_code !== key_want)
          report_error($sformatf("key_code %0d, expected %0d at %0t",
                                 key_code, key_want, $time));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("ERROR: no beat moved for %0d cycles", QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_events();
    test_hold_saturation();
    test_zero_settings();
    test_threshold_lowered();
    test_ignored_index();
    test_backpressure();
    test_random_phases();
    wait_drained();
    cfg_release();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_keys.size() != 0)
      report_error($sformatf("%0d key codes never arrived", expected_keys.size()));
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
